### src/unique_with_index_macros.svh
// Assertion macros shared by the RTL. Each use stands on a line of its own.
`ifndef UNIQUE_WITH_INDEX_MACROS_SVH
`define UNIQUE_WITH_INDEX_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UWI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UWI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/uwi_pkg.sv
package uwi_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_WIDTH   = 64;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int ID_W        = 64;
	localparam int SLOT_W      = 10;
	localparam int COUNT_W     = 11;
	localparam int EPOCH_W     = 8;

	// Hash: low bits of (key * HASH_MUL) ^ ((key * HASH_MUL) >> HASH_SHIFT).
	localparam logic [63:0] HASH_MUL = 64'h9E37_79B9_7F4A_7C15;
	localparam int HASH_SHIFT = 29;
	localparam int HASH_BITS  = HASH_SHIFT + ADDR_W;
	localparam int LO_W       = (HASH_BITS + 1) / 2;
	localparam int HI_W       = HASH_BITS - LO_W;

	// Memory word: epoch tag, key, slot number.
	localparam int ENTRY_W = EPOCH_W + KEY_WIDTH + SLOT_W;

	typedef struct packed {
		logic signed [ID_W-1:0] id_value;
		logic                   batch_end;
	} item_t;

	typedef struct packed {
		logic [SLOT_W-1:0]      slot_index;
		logic                   is_new;
		logic signed [ID_W-1:0] unique_value;
		logic [COUNT_W-1:0]     distinct_count;
		logic                   overflow_flag;
		logic                   count_mismatch;
		logic                   result_last;
	} result_t;

	typedef struct packed {
		logic [EPOCH_W-1:0]   tag;
		logic [KEY_WIDTH-1:0] key;
		logic [SLOT_W-1:0]    slot;
	} entry_t;

endpackage

### src/uwi_ram.sv
module uwi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/unique_with_index.sv
// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_ready      uwi_pkg::item_t
// result    out        result_valid / result_ready  uwi_pkg::result_t
// cfg       in         cfg_valid / cfg_ready        expected_unique_count
//
// An item passes the hash states, then a probe and a check per entry probed
// (at least one), then a final state. The hash is formed by one 20x20
// multiplier shared over the hash states; each probe is one read of the
// two-port table memory plus a compare. After reset and every 255th batch,
// a clearing pass writes every table entry while no item is accepted.
// A stalled result holds in the output register; the next item is accepted
// and worked on, and only its final cycle waits for the result to be taken.
`include "unique_with_index_macros.svh"

module unique_with_index (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  uwi_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output uwi_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [uwi_pkg::COUNT_W-1:0]     cfg_data
);

	import uwi_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH0,
		ST_HASH1,
		ST_HASH2,
		ST_PROBE,
		ST_CHECK,
		ST_FINISH
	} state_t;

	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
	localparam logic [COUNT_W-1:0] COUNT_FULL  = COUNT_W'(TABLE_DEPTH);
	localparam logic [HASH_BITS-1:0] MUL_BITS  = HASH_MUL[HASH_BITS-1:0];

	state_t                 state_q;
	logic [ADDR_W-1:0]      clr_addr_q;
	logic [EPOCH_W-1:0]     epoch_q;
	logic [COUNT_W-1:0]     expected_q;
	logic [COUNT_W-1:0]     counter_q;
	logic                   overflow_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic                   last_q;
	logic [HASH_BITS-1:0]   hash_q;
	logic [ADDR_W-1:0]      pos_q;
	logic [COUNT_W-1:0]     probes_q;
	logic                   found_q;
	logic                   empty_q;
	logic [SLOT_W-1:0]      hit_slot_q;
	logic                   result_valid_q;
	result_t                result_q;

	// Hash multiplier, shared over the hash states.
	logic [LO_W-1:0]        mul_a;
	logic [LO_W-1:0]        mul_b;
	logic [2*LO_W-1:0]      mul_p;
	logic [HASH_BITS-1:0]   key_bits;
	logic [HASH_BITS-1:0]   hash_sum;

	// Memory port signals.
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	entry_t                 ram_wdata;
	logic                   ram_re;
	entry_t                 ram_rdata;

	// Decision for the item in the final cycle.
	logic                   fresh;
	logic                   ovf_now;
	logic                   ovf_next;
	logic [COUNT_W-1:0]     count_next;
	logic                   out_free;
	logic                   load_result;

	assign key_bits = HASH_BITS'(64'(key_q));

	always_comb begin
		mul_a = key_bits[LO_W-1:0];
		mul_b = MUL_BITS[LO_W-1:0];
		unique case (state_q)
			ST_HASH1: mul_b = LO_W'(MUL_BITS[HASH_BITS-1:LO_W]);
			ST_HASH2: mul_a = LO_W'(key_bits[HASH_BITS-1:LO_W]);
			default: ;
		endcase
	end

	assign mul_p    = (2*LO_W)'(mul_a) * (2*LO_W)'(mul_b);
	assign hash_sum = hash_q + {mul_p[HI_W-1:0], LO_W'(0)};

	assign out_free    = !result_valid_q || result_ready;
	assign load_result = (state_q == ST_FINISH) && out_free;
	assign fresh       = !found_q && empty_q && (counter_q < COUNT_FULL);
	assign ovf_now     = !found_q && !fresh;
	assign ovf_next    = overflow_q || ovf_now;
	assign count_next  = fresh ? counter_q + COUNT_W'(1) : counter_q;

	// Table writes: the clearing pass tags every entry with an epoch no
	// batch uses; a fresh key is written in the final cycle of its item.
	// The next read of the table comes only after the next item's hash
	// states, so no read can meet a pending write to the same entry.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = '{tag: epoch_q, key: key_q, slot: SLOT_W'(counter_q)};
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '{tag: '0, key: '0, slot: '0};
		end else if (state_q == ST_FINISH && out_free && fresh) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re = (state_q == ST_PROBE);

	uwi_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	assign item_ready   = (state_q == ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_addr_q     <= '0;
			epoch_q        <= EPOCH_FIRST;
			expected_q     <= '0;
			counter_q      <= '0;
			overflow_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				expected_q <= cfg_data;
			end
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
						epoch_q <= EPOCH_FIRST;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						key_q   <= item.id_value[KEY_WIDTH-1:0];
						last_q  <= item.batch_end;
						state_q <= ST_HASH0;
					end
				end
				ST_HASH0: begin
					hash_q  <= mul_p[HASH_BITS-1:0];
					state_q <= ST_HASH1;
				end
				ST_HASH1: begin
					hash_q  <= hash_sum;
					state_q <= ST_HASH2;
				end
				ST_HASH2: begin
					pos_q    <= hash_sum[ADDR_W-1:0] ^ hash_sum[HASH_BITS-1:HASH_SHIFT];
					probes_q <= '0;
					found_q  <= 1'b0;
					empty_q  <= 1'b0;
					state_q  <= ST_PROBE;
				end
				ST_PROBE: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (ram_rdata.tag != epoch_q) begin
						empty_q <= 1'b1;
						state_q <= ST_FINISH;
					end else if (ram_rdata.key == key_q) begin
						found_q    <= 1'b1;
						hit_slot_q <= ram_rdata.slot;
						state_q    <= ST_FINISH;
					end else if (probes_q == COUNT_W'(TABLE_DEPTH - 1)) begin
						// Every entry holds another key: the table is full.
						state_q <= ST_FINISH;
					end else begin
						pos_q    <= pos_q + ADDR_W'(1);
						probes_q <= probes_q + COUNT_W'(1);
						state_q  <= ST_PROBE;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						result_q.slot_index     <= found_q ? hit_slot_q :
							(fresh ? SLOT_W'(counter_q) : '0);
						result_q.is_new         <= fresh;
						result_q.unique_value   <= ID_W'(signed'(key_q));
						result_q.distinct_count <= count_next;
						result_q.overflow_flag  <= ovf_next;
						result_q.count_mismatch <= last_q &&
							(ovf_next || count_next != expected_q);
						result_q.result_last    <= last_q;
						if (last_q) begin
							// End of batch: a new epoch (or a clearing pass) retires every entry.
							counter_q  <= '0;
							overflow_q <= 1'b0;
							if (epoch_q == EPOCH_LAST) begin
								clr_addr_q <= '0;
								state_q    <= ST_CLEAR;
							end else begin
								epoch_q <= epoch_q + EPOCH_W'(1);
								state_q <= ST_IDLE;
							end
						end else begin
							counter_q  <= count_next;
							overflow_q <= ovf_next;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A new key always takes the next number, one below the count after it.
	`UWI_ASSERT_NOW(a_new_numbering, result_valid && result.is_new, result.slot_index == SLOT_W'(result.distinct_count - COUNT_W'(1)), "new key numbered out of order")
	// The mismatch flag is only reported on the last result of a batch.
	`UWI_ASSERT_NOW(a_mismatch_last, result_valid && !result.result_last, !result.count_mismatch, "mismatch outside batch end")
	// No item is taken while the clearing pass runs.
	`UWI_ASSERT_NOW(a_no_item_clear, state_q == ST_CLEAR, !item_ready, "item accepted during clearing pass")
	// A new result is only loaded once the previous one has been taken.
	`UWI_ASSERT_NEXT(a_no_overwrite, state_q == ST_FINISH && !out_free, state_q == ST_FINISH, "result overwritten")

endmodule

### tb/unique_with_index_tb.sv
module unique_with_index_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import uwi_pkg::*;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;
	logic    cfg_valid;
	logic    cfg_ready;
	logic [COUNT_W-1:0] cfg_data;

	unique_with_index i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Our own copy of the numbering table. It is a linear-probing hash table
	// with the same home position as the block, so that the slot numbers and
	// the point at which the table counts as full come out the same.
	logic [KEY_WIDTH-1:0] model_key [TABLE_DEPTH];
	bit                   model_used [TABLE_DEPTH];
	logic [SLOT_W-1:0]    model_slot [TABLE_DEPTH];
	int unsigned          model_held;
	bit                   model_overflow;
	logic [COUNT_W-1:0]   model_expected;

	// Results still owed by the block, oldest first.
	result_t     numbering_queue[$];
	int unsigned error_count;
	// While quiet is set, neither side inserts idle cycles.
	bit          quiet;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [ADDR_W-1:0] home_slot(logic [KEY_WIDTH-1:0] key);
		logic [63:0] h;
		h = key * HASH_MUL;
		h = h ^ (h >> HASH_SHIFT);
		return h[ADDR_W-1:0];
	endfunction

	function automatic void clear_numbering();
		foreach (model_used[i])
			model_used[i] = 1'b0;
		model_held = 0;
		model_overflow = 1'b0;
	endfunction

	// Works out the result of one transfer on the item channel and updates
	// the table copy, including the clear at the end of a batch.
	function automatic result_t predict_numbering(item_t it);
		result_t          r;
		logic [ADDR_W-1:0] pos;
		bit               found;
		bit               empty_hit;
		logic [KEY_WIDTH-1:0] key;
		key = it.id_value;
		pos = home_slot(key);
		found = 1'b0;
		empty_hit = 1'b0;
		r = '0;
		for (int n = 0; n < TABLE_DEPTH; n++) begin
			if (!model_used[pos]) begin
				empty_hit = 1'b1;
				break;
			end
			if (model_key[pos] == key) begin
				found = 1'b1;
				break;
			end
			pos = pos + 1'b1;
		end
		if (found) begin
			r.slot_index = model_slot[pos];
		end else if (empty_hit && model_held < TABLE_DEPTH) begin
			model_used[pos] = 1'b1;
			model_key[pos]  = key;
			model_slot[pos] = model_held[SLOT_W-1:0];
			r.slot_index    = model_held[SLOT_W-1:0];
			r.is_new        = 1'b1;
			model_held++;
		end else begin
			model_overflow = 1'b1;
		end
		r.unique_value   = it.id_value;
		r.distinct_count = model_held[COUNT_W-1:0];
		r.overflow_flag  = model_overflow;
		r.result_last    = it.batch_end;
		if (it.batch_end) begin
			r.count_mismatch = model_overflow || (model_held != model_expected);
			clear_numbering();
		end
		return r;
	endfunction

	task automatic note_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("%0t ns: result field %s is %h, expected %h", $realtime, field, got, want);
		error_count++;
	endtask

	task automatic compare_field(string field, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			note_mismatch(field, got, want);
	endtask

	// Every transfer on the result channel is held against the oldest
	// expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (numbering_queue.size() == 0) begin
				note_mismatch("(unexpected result)", result.unique_value, '0);
			end else begin
				want = numbering_queue.pop_front();
				compare_field("slot_index", result.slot_index, want.slot_index);
				compare_field("is_new", result.is_new, want.is_new);
				compare_field("unique_value", result.unique_value, want.unique_value);
				compare_field("distinct_count", result.distinct_count, want.distinct_count);
				compare_field("overflow_flag", result.overflow_flag, want.overflow_flag);
				compare_field("count_mismatch", result.count_mismatch, want.count_mismatch);
				compare_field("result_last", result.result_last, want.result_last);
			end
		end
	end

	// The consumer stalls in random bursts unless the run has gone quiet.
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 18) - 1) @(negedge clk);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Sends one ID. The valid stays high after the transfer so that the next
	// call can follow back to back; an idle gap lowers it.
	task automatic send_id(logic [63:0] id, bit last);
		item_t it;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 18) - 1) @(negedge clk);
		end
		it.id_value  = id;
		it.batch_end = last;
		@(negedge clk);
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		numbering_queue.push_back(predict_numbering(it));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (numbering_queue.size() != 0)
			@(posedge clk);
	endtask

	// The register is only written once the block has handed over every
	// result it owes.
	task automatic write_expected(int unsigned count);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= count[COUNT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		model_expected = count[COUNT_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] random_id();
		return {$urandom(), $urandom()};
	endfunction

	// Field extremes, repeats, a batch that matches the expected count and
	// one that does not.
	task automatic test_extremes();
		write_expected(5);
		send_id(64'h8000_0000_0000_0000, 1'b0);
		send_id(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		send_id(64'h0, 1'b0);
		send_id(64'h8000_0000_0000_0000, 1'b0);
		send_id(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		send_id(64'h0, 1'b0);
		send_id(64'h1, 1'b1);
		write_expected(0);
		send_id(64'h5555_5555_5555_5555, 1'b0);
		send_id(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_id(64'h5555_5555_5555_5555, 1'b1);
		// A lone repeat of the previous batch's key: the table must be empty again.
		send_id(64'h5555_5555_5555_5555, 1'b1);
	endtask

	// Several keys that share one home position, so lookups have to walk
	// past occupied entries, including the wrap at the top of the table.
	task automatic test_collisions();
		logic [63:0] chain [6];
		logic [63:0] cand;
		logic [ADDR_W-1:0] target;
		int got;
		write_expected(6);
		target = {ADDR_W{1'b1}};
		got = 0;
		while (got < 6) begin
			cand = random_id();
			if (home_slot(cand) == target) begin
				chain[got] = cand;
				got++;
			end
		end
		foreach (chain[i])
			send_id(chain[i], 1'b0);
		send_id(chain[5], 1'b0);
		send_id(chain[2], 1'b0);
		send_id(chain[0], 1'b1);
	endtask

	// Fill the table to its depth, with the expected count set to it, repeat a
	// key, then push a fresh key in: the overflow must set and stick, and the
	// batch end must report a mismatch.
	task automatic test_full_table();
		write_expected(TABLE_DEPTH);
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_id(64'h0123_4567_0000_0000 + i, 1'b0);
		send_id(64'h0123_4567_0000_0007, 1'b0);
		send_id(64'hDEAD_0000_0000_0001, 1'b0);
		send_id(64'h0123_4567_0000_0003, 1'b0);
		send_id(64'hDEAD_0000_0000_0002, 1'b1);
	endtask

	// Many one-ID batches, enough to carry the block past its periodic
	// clearing pass.
	task automatic test_many_batches();
		for (int i = 0; i < 260; i++)
			send_id(random_id(), 1'b1);
	endtask

	// Batches of random length drawn mostly from a small pool of keys, so
	// that repeats are common; the expected count is often set to the true
	// count of the next batch.
	task automatic test_random_batches(int unsigned items);
		logic [63:0] pool [16];
		logic [63:0] ids [$];
		bit          seen [logic [63:0]];
		int unsigned sent;
		int unsigned len;
		sent = 0;
		foreach (pool[i])
			pool[i] = random_id();
		while (sent < items) begin
			ids.delete();
			seen.delete();
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				ids.push_back($urandom_range(0, 2) == 0 ? random_id() :
					pool[$urandom_range(0, 15)]);
				seen[ids[i]] = 1'b1;
			end
			if (sent + 40 > items)
				quiet = 1'b1;
			case ($urandom_range(0, 3))
				0: write_expected(seen.num());
				1: write_expected($urandom_range(0, TABLE_DEPTH));
				default: ;
			endcase
			foreach (ids[i])
				send_id(ids[i], i == len - 1);
			sent += len;
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		quiet      = 1'b0;
		error_count = 0;
		model_expected = '0;
		clear_numbering();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_collisions();
		test_full_table();
		test_many_batches();
		test_random_batches(100);

		wait_drained();
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/uwi_pkg.sv
src/uwi_ram.sv
src/unique_with_index.sv
tb/unique_with_index_tb.sv
